// File: design/ta3_pkg.sv
`timescale 1ns / 1ps

package ta3_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int AREA_WIDTH      = 36;

endpackage

// File: design/ta3_if.sv
`timescale 1ns / 1ps

interface ta3_in_if import ta3_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] az;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by_coord;
  logic signed [COORD_WIDTH-1:0] bz;
  logic signed [COORD_WIDTH-1:0] cx;
  logic signed [COORD_WIDTH-1:0] cy;
  logic signed [COORD_WIDTH-1:0] cz;

  modport source (
    output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
    input  ready
  );

  modport sink (
    input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
    output ready
  );
endinterface

interface ta3_out_if import ta3_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [AREA_WIDTH-1:0] area;

  modport source (
    output valid, area,
    input  ready
  );

  modport sink (
    input  valid, area,
    output ready
  );
endinterface

// File: design/triangle_area_3d_top.sv
`timescale 1ns / 1ps

// Streams one triangle per clock while the output is not stalled: each item
// carries points A, B and C and returns floor(sqrt(|AB x AC|^2)) / 2 as an
// unsigned integer, saturated to 36 bits. The pipeline registers, in order, are
// edge vectors, products, cross product, magnitudes, split squares, squares and
// their sum, then the square-root pipeline, and the output register. A stalled
// output freezes every stage, so nothing is lost or repeated.
module triangle_area_3d_top import ta3_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ta3_in_if.sink     in_if,
  ta3_out_if.source  out_if
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int KW  = PW + 1;
  localparam int MW  = PW;
  localparam int LW  = MW / 2;
  localparam int HW  = MW - LW;
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;
  localparam int RW  = MW + 1;
  localparam int AFW = RW - 1;
  localparam int EXW = (AFW > AREA_WIDTH) ? AFW : AREA_WIDTH + 1;

  logic en;
  logic [6:0] front_vld_r;
  logic out_valid_r;
  logic [AREA_WIDTH-1:0] out_area_r;

  logic signed [DW-1:0] u_r [3];
  logic signed [DW-1:0] w_r [3];
  logic signed [PW-1:0] p_r [6];
  logic signed [KW-1:0] k_r [3];
  logic [MW-1:0]        m_r [3];
  logic [2*HW-1:0]      hh_r [3];
  logic [HW+LW-1:0]     hl_r [3];
  logic [2*LW-1:0]      ll_r [3];
  logic [SQW-1:0]       sq_r [3];
  logic [SW-1:0]        s_r;

  logic [RW-1:0]   rt_vld_r;
  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [SW-1:0]   sh_r   [RW];

  logic [AFW-1:0]  area_full;
  logic [EXW-1:0]  area_ext;
  logic            area_sat;

  assign en           = !out_valid_r || out_if.ready;
  assign in_if.ready  = en;
  assign out_if.valid = out_valid_r;
  assign out_if.area  = out_area_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_vld_r <= '0;
      rt_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      front_vld_r <= {front_vld_r[5:0], in_if.valid};
      rt_vld_r    <= {rt_vld_r[RW-2:0], front_vld_r[6]};
      out_valid_r <= rt_vld_r[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0] <= DW'(in_if.bx) - DW'(in_if.ax);
      u_r[1] <= DW'(in_if.by_coord) - DW'(in_if.ay);
      u_r[2] <= DW'(in_if.bz) - DW'(in_if.az);
      w_r[0] <= DW'(in_if.cx) - DW'(in_if.ax);
      w_r[1] <= DW'(in_if.cy) - DW'(in_if.ay);
      w_r[2] <= DW'(in_if.cz) - DW'(in_if.az);

      p_r[0] <= u_r[1] * w_r[2];
      p_r[1] <= u_r[2] * w_r[1];
      p_r[2] <= u_r[2] * w_r[0];
      p_r[3] <= u_r[0] * w_r[2];
      p_r[4] <= u_r[0] * w_r[1];
      p_r[5] <= u_r[1] * w_r[0];

      for (int j = 0; j < 3; j++) begin
        k_r[j]  <= KW'(p_r[2*j]) - KW'(p_r[2*j+1]);
        m_r[j]  <= k_r[j][KW-1] ? MW'(-k_r[j]) : MW'(k_r[j]);
        hh_r[j] <= m_r[j][MW-1:LW] * m_r[j][MW-1:LW];
        hl_r[j] <= m_r[j][MW-1:LW] * m_r[j][LW-1:0];
        ll_r[j] <= m_r[j][LW-1:0] * m_r[j][LW-1:0];
        sq_r[j] <= (SQW'(hh_r[j]) << (2 * LW)) + (SQW'(hl_r[j]) << (LW + 1))
                   + SQW'(ll_r[j]);
      end

      s_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
    end
  end

  // Restoring square root, one result bit per stage.
  for (genvar i = 0; i < RW; i++) begin : g_root
    logic [RW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [SW-1:0] sh_in;
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign sh_in   = s_r;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign sh_in   = sh_r[i-1];
    end

    assign cur   = {rem_in, sh_in[SW-1 -: 2]};
    assign trial = (RW+4)'({root_in, 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? (RW+2)'(cur - trial) : (RW+2)'(cur);
        root_r[i] <= {root_in[RW-2:0], ge};
        sh_r[i]   <= sh_in << 2;
      end
    end
  end

  assign area_full = root_r[RW-1][RW-1:1];
  assign area_ext  = EXW'(area_full);
  assign area_sat  = |area_ext[EXW-1:AREA_WIDTH];

  always_ff @(posedge clk) begin
    if (en) begin
      out_area_r <= area_sat ? '1 : area_ext[AREA_WIDTH-1:0];
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |-> !in_if.ready)
    else $error("Input taken while the output item is stalled.");

  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && $past(rst_n)) |=> ($stable(rt_vld_r) && $stable(front_vld_r)))
    else $error("Pipeline valid bits moved during a stall.");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> (out_valid_r && $stable(out_area_r)))
    else $error("Stalled output item changed.");

endmodule
